FILE: design/annexb_pkg.sv
// Shared types and constants for the Annex B unit splitter.
// No dependencies.
package annexb_pkg;

    localparam int unsigned POS_W   = 25;
    localparam int unsigned START_W = 24;
    localparam int unsigned IDX_W   = 32;
    localparam logic [POS_W-1:0] MAX_PICTURE_BYTES = 25'd16777216;

    localparam logic [1:0] MODE_H264  = 2'd0;
    localparam logic [1:0] MODE_HEVC  = 2'd1;

    localparam logic [7:0] H264_TYPE_MASK = 8'h1f;
    localparam logic [7:0] HEVC_TYPE_MASK = 8'h3f;
    localparam logic [4:0] H264_SPS = 5'd7;
    localparam logic [4:0] H264_PPS = 5'd8;
    localparam logic [5:0] HEVC_VPS = 6'd32;
    localparam logic [5:0] HEVC_SPS = 6'd33;
    localparam logic [5:0] HEVC_PPS = 6'd34;

    localparam logic [2:0] REG_CODEC_MODE = 3'd0;

    typedef struct packed {
        logic [START_W-1:0] unit_start;
        logic [POS_W-1:0]   unit_length;
        logic               param_set;
        logic [IDX_W-1:0]   unit_index;
        logic               picture_done;
        logic [IDX_W-1:0]   picture_last_index;
        logic               overflow;
        logic               last;
    } result_t;

endpackage

FILE: design/annexb_if.sv
// Stream interfaces for picture bytes in and unit descriptors out.
// Depends on annexb_pkg.
interface annexb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface annexb_out_if import annexb_pkg::*;;
    logic                valid;
    logic                ready;
    logic [START_W-1:0]  unit_start;
    logic [POS_W-1:0]    unit_length;
    logic                param_set;
    logic [IDX_W-1:0]    unit_index;
    logic                picture_done;
    logic [IDX_W-1:0]    picture_last_index;
    logic                overflow;
    logic                last;

    modport source (output valid, output unit_start, output unit_length, output param_set,
                    output unit_index, output picture_done, output picture_last_index,
                    output overflow, output last, input ready);
    modport sink   (input valid, input unit_start, input unit_length, input param_set,
                    input unit_index, input picture_done, input picture_last_index,
                    input overflow, input last, output ready);
endinterface

FILE: design/annexb_nal_unit_splitter_top.sv
// Annex B start code parser: splits a picture byte stream into unit descriptors.
// Results of a byte are registered into the result queue when the byte is accepted.
// Throughput: one byte per cycle; a 4-entry result queue accepts a byte whenever
// at most one result is queued, so a byte that yields two or three results
// holds the input until the queue drains to one entry.
// Reset (rst_n, async low) clears parser state, unit counter, mode and queue.
module annexb_nal_unit_splitter_top import annexb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    annexb_in_if.sink   in_ch,
    annexb_out_if.source out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]         mode_reg;
    logic [1:0]         zero_run_reg, zero_run_next;
    logic               inside_reg, inside_next;
    logic [START_W-1:0] cur_start_reg, cur_start_next;
    logic [POS_W-1:0]   trimmed_reg, trimmed_next;
    logic               awaiting_reg, awaiting_next;
    logic               hparam_reg, hparam_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [IDX_W-1:0]   counted_reg, counted_next;
    logic [IDX_W-1:0]   plc_reg, plc_next;
    logic               ovf_reg, ovf_next;

    result_t            fifo_reg [4];
    logic [1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [2:0]         count_reg;

    result_t            res [3];
    logic [1:0]         n_res;
    logic               accept, pop;

    function automatic logic classify(input logic [1:0] mode, input logic [7:0] b);
        logic [7:0] t;
        begin
            t = 8'h00;
            if (mode == MODE_H264)
            begin
                t = b & H264_TYPE_MASK;
                return t[4:0] == H264_SPS || t[4:0] == H264_PPS;
            end
            if (mode == MODE_HEVC)
            begin
                t = (b >> 1) & HEVC_TYPE_MASK;
                return t[5:0] == HEVC_VPS || t[5:0] == HEVC_SPS || t[5:0] == HEVC_PPS;
            end
            return 1'b0;
        end
    endfunction

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr == REG_CODEC_MODE) ? {30'd0, mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 2'd0;
        else if (psel && penable && pwrite && paddr[2] == REG_CODEC_MODE[2])
            mode_reg <= pwdata[1:0];
    end

    assign in_ch.ready = (count_reg <= 3'd1);
    assign accept      = in_ch.valid && in_ch.ready;
    assign pop         = out_ch.valid && out_ch.ready;

    // per-byte parse
    always_comb
    begin
        logic               in_range, sc, split, hp_eff;
        logic               emit_a, emit_b, cnt_a, cnt_b;
        logic [POS_W-1:0]   p;
        logic [IDX_W-1:0]   cnt_after_a;
        logic [IDX_W-1:0]   plc_after_a;
        result_t            ra, rb, rs;
        logic [7:0]         b;

        b        = in_ch.byte_value;
        p        = pos_reg;
        split    = (mode_reg == MODE_H264) || (mode_reg == MODE_HEVC);
        in_range = pos_reg < MAX_PICTURE_BYTES;

        zero_run_next  = zero_run_reg;
        inside_next    = inside_reg;
        cur_start_next = cur_start_reg;
        trimmed_next   = trimmed_reg;
        awaiting_next  = awaiting_reg;
        hparam_next    = hparam_reg;
        pos_next       = pos_reg;
        ovf_next       = ovf_reg;
        counted_next   = counted_reg;
        plc_next       = plc_reg;

        hp_eff = hparam_reg;
        sc     = 1'b0;
        if (in_range)
        begin
            pos_next = p + 25'd1;
            if (awaiting_reg)
            begin
                awaiting_next = 1'b0;
                hp_eff        = classify(mode_reg, b);
            end
            hparam_next = hp_eff;
            sc = (b == 8'd1) && (zero_run_reg >= 2'd2);
            if (sc)
            begin
                inside_next    = 1'b1;
                cur_start_next = START_W'(p - 25'd2);
                trimmed_next   = p + 25'd1;
                awaiting_next  = 1'b1;
                hparam_next    = 1'b0;
                zero_run_next  = 2'd0;
            end
            else if (b == 8'd0)
            begin
                if (zero_run_reg < 2'd2)
                    zero_run_next = zero_run_reg + 2'd1;
            end
            else
            begin
                zero_run_next = 2'd0;
                if (inside_reg)
                    trimmed_next = p + 25'd1;
            end
        end
        else
        begin
            ovf_next = 1'b1;
        end

        // unit closed by a new start code
        emit_a      = sc && inside_reg && split;
        cnt_a       = emit_a && !hp_eff;
        cnt_after_a = counted_reg + {31'd0, cnt_a};
        plc_after_a = cnt_a ? cnt_after_a : plc_reg;

        ra = '0;
        ra.unit_start  = cur_start_reg;
        ra.unit_length = trimmed_reg - {1'b0, cur_start_reg};
        ra.param_set   = hp_eff;
        ra.unit_index  = cnt_a ? cnt_after_a : '0;

        // final unit at picture end
        rb = '0;
        if (split)
        begin
            emit_b         = in_ch.last_byte && inside_next;
            rb.unit_start  = cur_start_next;
            rb.unit_length = pos_next - {1'b0, cur_start_next};
            rb.param_set   = hparam_next;
        end
        else
        begin
            emit_b         = in_ch.last_byte;
            rb.unit_length = pos_next;
        end
        cnt_b         = emit_b && !rb.param_set;
        rb.unit_index = cnt_b ? cnt_after_a + 32'd1 : '0;

        rs = '0;
        rs.picture_done       = 1'b1;
        rs.picture_last_index = cnt_b ? rb.unit_index : plc_after_a;
        rs.overflow           = ovf_next;
        rs.last               = 1'b1;

        counted_next = cnt_b ? rb.unit_index : cnt_after_a;
        plc_next     = plc_after_a;

        if (in_ch.last_byte)
        begin
            zero_run_next  = 2'd0;
            inside_next    = 1'b0;
            cur_start_next = '0;
            trimmed_next   = '0;
            awaiting_next  = 1'b0;
            hparam_next    = 1'b0;
            pos_next       = '0;
            plc_next       = '0;
            ovf_next       = 1'b0;
        end

        // compact results in order
        res[0] = '0;
        res[1] = '0;
        res[2] = '0;
        n_res  = 2'd0;
        if (emit_a)
        begin
            ra.last    = !in_ch.last_byte;
            res[0]     = ra;
            n_res      = 2'd1;
        end
        if (emit_b)
        begin
            res[n_res] = rb;
            n_res      = n_res + 2'd1;
        end
        if (in_ch.last_byte)
        begin
            res[n_res] = rs;
            n_res      = n_res + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_run_reg  <= 2'd0;
            inside_reg    <= 1'b0;
            cur_start_reg <= '0;
            trimmed_reg   <= '0;
            awaiting_reg  <= 1'b0;
            hparam_reg    <= 1'b0;
            pos_reg       <= '0;
            counted_reg   <= '0;
            plc_reg       <= '0;
            ovf_reg       <= 1'b0;
        end
        else if (accept)
        begin
            zero_run_reg  <= zero_run_next;
            inside_reg    <= inside_next;
            cur_start_reg <= cur_start_next;
            trimmed_reg   <= trimmed_next;
            awaiting_reg  <= awaiting_next;
            hparam_reg    <= hparam_next;
            pos_reg       <= pos_next;
            counted_reg   <= counted_next;
            plc_reg       <= plc_next;
            ovf_reg       <= ovf_next;
        end
    end

    // result queue
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (2'(k) < n_res)
                    fifo_reg[wr_ptr_reg + 2'(k)] <= res[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            if (accept)
                wr_ptr_reg <= wr_ptr_reg + n_res;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + (accept ? {1'b0, n_res} : 3'd0) - {2'd0, pop};
        end
    end

    assign out_ch.valid              = (count_reg != 3'd0);
    assign out_ch.unit_start         = fifo_reg[rd_ptr_reg].unit_start;
    assign out_ch.unit_length        = fifo_reg[rd_ptr_reg].unit_length;
    assign out_ch.param_set          = fifo_reg[rd_ptr_reg].param_set;
    assign out_ch.unit_index         = fifo_reg[rd_ptr_reg].unit_index;
    assign out_ch.picture_done       = fifo_reg[rd_ptr_reg].picture_done;
    assign out_ch.picture_last_index = fifo_reg[rd_ptr_reg].picture_last_index;
    assign out_ch.overflow           = fifo_reg[rd_ptr_reg].overflow;
    assign out_ch.last               = fifo_reg[rd_ptr_reg].last;

endmodule

FILE: test/annexb_nal_unit_splitter_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for annexb_nal_unit_splitter_top: directed byte table, then random
// pictures of start codes and headers under all codec modes, checked against a predictor.
// Depends on annexb_pkg, annexb_in_if, annexb_out_if and annexb_nal_unit_splitter_top.
module annexb_nal_unit_splitter_top_test;
    import annexb_pkg::*;

    localparam logic [1:0] MODE_WHOLE     = 2'd2;
    localparam logic [1:0] MODE_WHOLE_ALT = 2'd3;
    localparam int RANDOM_BYTES   = 360;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct {
        logic [7:0]  b;
        logic        lb;
        logic        typed;
        logic [31:0] pic_last;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    annexb_in_if  in_ch ();
    annexb_out_if out_ch ();

    // travels with the beat: typed summary index for directed rows
    logic        tag_typed;
    logic [31:0] tag_pic_last;

    annexb_nal_unit_splitter_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    stim_row_t directed_rows [24] = '{
        '{8'h00, 1'b0, 1'b0, 32'd0}, '{8'h00, 1'b0, 1'b0, 32'd0}, '{8'h01, 1'b0, 1'b0, 32'd0},
        '{8'h67, 1'b0, 1'b0, 32'd0}, '{8'h00, 1'b0, 1'b0, 32'd0}, '{8'h00, 1'b0, 1'b0, 32'd0},
        '{8'h00, 1'b0, 1'b0, 32'd0}, '{8'h01, 1'b0, 1'b0, 32'd0}, '{8'h68, 1'b0, 1'b0, 32'd0},
        '{8'h00, 1'b0, 1'b0, 32'd0}, '{8'h00, 1'b0, 1'b0, 32'd0}, '{8'h01, 1'b0, 1'b0, 32'd0},
        '{8'h65, 1'b0, 1'b0, 32'd0}, '{8'hFF, 1'b0, 1'b0, 32'd0}, '{8'h00, 1'b1, 1'b1, 32'd1},
        '{8'hAB, 1'b0, 1'b0, 32'd0}, '{8'h00, 1'b0, 1'b0, 32'd0}, '{8'h00, 1'b0, 1'b0, 32'd0},
        '{8'h01, 1'b0, 1'b0, 32'd0}, '{8'h00, 1'b0, 1'b0, 32'd0}, '{8'h00, 1'b0, 1'b0, 32'd0},
        '{8'h01, 1'b0, 1'b0, 32'd0}, '{8'h41, 1'b1, 1'b1, 32'd3}, '{8'hFF, 1'b1, 1'b1, 32'd0}
    };

    logic [1:0] mode_plan [4] = '{MODE_HEVC, MODE_WHOLE, MODE_WHOLE_ALT, MODE_H264};

    // predictor state
    logic [1:0]  codec_mode_q = MODE_H264;
    logic [1:0]  zero_run     = '0;
    logic        in_unit      = 1'b0;
    logic [23:0] unit_begin   = '0;
    logic [24:0] trim_end     = '0;
    logic        want_header  = 1'b0;
    logic        hdr_param    = 1'b0;
    logic [24:0] pic_pos      = '0;
    logic [31:0] unit_count   = '0;
    logic [31:0] pic_last     = '0;
    logic        ovf          = 1'b0;

    result_t    pending_units [$];
    logic [7:0] picture_bytes [$];

    logic steady = 1'b0;
    int fault_count  = 0;
    int stall_cycles = 0;
    int bytes_sent   = 0;
    int units_seen   = 0;
    int params_seen  = 0;
    int pics_seen    = 0;
    int mode_writes  = 0;

    function automatic logic splitting();
        return codec_mode_q == MODE_H264 || codec_mode_q == MODE_HEVC;
    endfunction

    task automatic emit_unit(input logic [23:0] start, input logic [24:0] len,
                             input logic param);
        result_t r;
        r = '0;
        r.unit_start  = start;
        r.unit_length = len;
        r.param_set   = param;
        if (!param)
        begin
            unit_count   = unit_count + 32'd1;
            r.unit_index = unit_count;
            pic_last     = unit_count;
        end
        pending_units.push_back(r);
    endtask

    task automatic split_byte(input logic [7:0] b, input logic lb, input logic typed,
                              input logic [31:0] typed_last);
        logic [24:0] p;
        logic [5:0]  hevc_type;
        result_t     r;
        int          first;
        first = pending_units.size();
        if (pic_pos < MAX_PICTURE_BYTES)
        begin
            p       = pic_pos;
            pic_pos = p + 25'd1;
            if (want_header)
            begin
                want_header = 1'b0;
                hevc_type   = 6'((b >> 1) & HEVC_TYPE_MASK);
                if (codec_mode_q == MODE_H264)
                    hdr_param = ((b & H264_TYPE_MASK) == H264_SPS)
                             || ((b & H264_TYPE_MASK) == H264_PPS);
                else if (codec_mode_q == MODE_HEVC)
                    hdr_param = hevc_type == HEVC_VPS || hevc_type == HEVC_SPS
                             || hevc_type == HEVC_PPS;
                else
                    hdr_param = 1'b0;
            end
            if (b == 8'h01 && zero_run >= 2)
            begin
                if (in_unit && splitting())
                    emit_unit(unit_begin, trim_end - unit_begin, hdr_param);
                in_unit     = 1'b1;
                unit_begin  = 24'(p - 2);
                trim_end    = p + 25'd1;
                want_header = 1'b1;
                hdr_param   = 1'b0;
                zero_run    = '0;
            end
            else if (b == 8'h00)
            begin
                if (zero_run < 2)
                    zero_run = zero_run + 2'd1;
            end
            else
            begin
                zero_run = '0;
                if (in_unit)
                    trim_end = p + 25'd1;
            end
        end
        else
            ovf = 1'b1;
        if (lb)
        begin
            if (splitting())
            begin
                if (in_unit)
                    emit_unit(unit_begin, pic_pos - unit_begin, hdr_param);
            end
            else
                emit_unit('0, pic_pos, 1'b0);
            r = '0;
            r.picture_done       = 1'b1;
            r.picture_last_index = typed ? typed_last : pic_last;
            r.overflow           = ovf;
            pending_units.push_back(r);
            zero_run    = '0;
            in_unit     = 1'b0;
            unit_begin  = '0;
            trim_end    = '0;
            want_header = 1'b0;
            hdr_param   = 1'b0;
            pic_pos     = '0;
            pic_last    = '0;
            ovf         = 1'b0;
        end
        if (pending_units.size() > first)
            pending_units[pending_units.size() - 1].last = 1'b1;
    endtask

    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                split_byte(in_ch.byte_value, in_ch.last_byte, tag_typed, tag_pic_last);
            if (out_ch.valid && out_ch.ready)
            begin
                got.unit_start         = out_ch.unit_start;
                got.unit_length        = out_ch.unit_length;
                got.param_set          = out_ch.param_set;
                got.unit_index         = out_ch.unit_index;
                got.picture_done       = out_ch.picture_done;
                got.picture_last_index = out_ch.picture_last_index;
                got.overflow           = out_ch.overflow;
                got.last               = out_ch.last;
                if (pending_units.size() == 0)
                begin
                    if (fault_count < 10)
                        $display("unexpected result beat: %p", got);
                    fault_count++;
                end
                else
                begin
                    want = pending_units.pop_front();
                    if (got !== want)
                    begin
                        if (fault_count < 10)
                            $display("mismatch: expected %p, got %p", want, got);
                        fault_count++;
                    end
                    if (want.picture_done)
                        pics_seen++;
                    else if (want.param_set)
                        params_seen++;
                    else
                        units_seen++;
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    initial
    begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no beat for %0d cycles, %0d results pending",
                 WATCHDOG_LIMIT, pending_units.size());
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic lb, input logic typed,
                             input logic [31:0] typed_last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.byte_value <= b;
        in_ch.last_byte  <= lb;
        tag_typed        <= typed;
        tag_pic_last     <= typed_last;
        do @(posedge clk); while (!in_ch.ready);
        bytes_sent++;
    endtask

    // drop valid, let the predictor take the last accepted byte, then wait for all results to drain
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_units.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(REG_CODEC_MODE * 4);
        pwdata  <= {30'd0, m};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        codec_mode_q = m;
        mode_writes++;
    endtask

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 5))
            0, 1:    return 8'h00;
            2:       return 8'h01;
            3:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] header_byte();
        logic [7:0] h;
        h = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0:       h[4:0] = ($urandom_range(0, 1) != 0) ? H264_SPS : H264_PPS;
            1:       h[6:1] = HEVC_VPS + 6'($urandom_range(0, 2));
            default: ;
        endcase
        return h;
    endfunction

    // mostly well-formed pictures with random content, some pure noise
    task automatic build_picture();
        int units, k, j, n;
        picture_bytes.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 12);
            for (j = 0; j < n; j++)
                picture_bytes.push_back(noise_byte());
        end
        else
        begin
            n = $urandom_range(0, 2);
            for (j = 0; j < n; j++)
                picture_bytes.push_back(8'($urandom_range(2, 255)));
            units = $urandom_range(1, 4);
            for (k = 0; k < units; k++)
            begin
                if ($urandom_range(0, 2) == 0)
                    picture_bytes.push_back(8'h00);
                picture_bytes.push_back(8'h00);
                picture_bytes.push_back(8'h00);
                picture_bytes.push_back(8'h01);
                if ($urandom_range(0, 7) != 0)
                    picture_bytes.push_back(header_byte());
                n = $urandom_range(0, 6);
                for (j = 0; j < n; j++)
                    picture_bytes.push_back(noise_byte());
                if ($urandom_range(0, 3) == 0)
                begin
                    n = $urandom_range(1, 3);
                    for (j = 0; j < n; j++)
                        picture_bytes.push_back(8'h00);
                end
            end
        end
    endtask

    initial
    begin
        int phase, phase_left, sent, j;
        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.byte_value <= '0;
        in_ch.last_byte  <= 1'b0;
        tag_typed        <= 1'b0;
        tag_pic_last     <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].b, directed_rows[i].lb, directed_rows[i].typed,
                      directed_rows[i].pic_last);

        // phase boundaries may fall mid-picture: mode changes between bytes
        phase      = 0;
        phase_left = 0;
        sent       = 0;
        while (sent < RANDOM_BYTES)
        begin
            build_picture();
            for (j = 0; j < picture_bytes.size(); j++)
            begin
                if (phase_left == 0)
                begin
                    settle();
                    write_mode(phase < 4 ? mode_plan[phase] : 2'($urandom_range(0, 3)));
                    steady     = ($urandom_range(0, 3) == 0);
                    phase_left = $urandom_range(45, 75);
                    phase++;
                end
                send_byte(picture_bytes[j], j == picture_bytes.size() - 1, 1'b0, '0);
                sent++;
                phase_left--;
            end
        end

        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_units.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d bytes in %0d pictures: %0d counted units, %0d parameter sets",
                 bytes_sent, pics_seen, units_seen, params_seen);
        $display("codec mode written %0d times across %0d random phases, %0d mismatches",
                 mode_writes, phase, fault_count);
        if (fault_count == 0 && pending_units.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
design/annexb_pkg.sv
design/annexb_if.sv
design/annexb_nal_unit_splitter_top.sv
test/annexb_nal_unit_splitter_top_test.sv
